@@ hw/rtl/der2r_pkg.sv @@
// Shared types and constants for the DER signature to raw r||s converter.
`timescale 1ns / 1ps

package der2r_pkg;

    // Status codes carried with every result word.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SEQ_TAG  = 3'd1;
    localparam logic [2:0] ST_INT_TAG  = 3'd2;
    localparam logic [2:0] ST_LONG_LEN = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;

    // DER tags and limits.
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] SHORT_LEN_MAX = 8'h7f;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;

    // Raw output layout: eight 64-bit words of r||s.
    localparam int OUT_WORDS = 8;
    localparam int WORD_BITS = 64;
    localparam int RAW_BITS  = OUT_WORDS * WORD_BITS;

    // Reported by the parser when the final byte of a signature is taken.
    typedef struct packed {
        logic       fire;
        logic [2:0] status;
    } done_t;

endpackage

@@ hw/rtl/der2r_parse.sv @@
// DER parser: tag and length checks, zero stripping and the r and s field shift registers.
`timescale 1ns / 1ps

module der2r_parse #(
    parameter int INT_BYTES = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       take,
    input  logic [7:0]                 byte_in,
    input  logic                       last_in,
    output der2r_pkg::done_t           done,
    output logic [2*INT_BYTES*8-1:0]   sig_next
);

    localparam int FB = INT_BYTES * 8;

    localparam logic [2:0] PH_SEQ_TAG = 3'd0;
    localparam logic [2:0] PH_SEQ_LEN = 3'd1;
    localparam logic [2:0] PH_INT_TAG = 3'd2;
    localparam logic [2:0] PH_INT_LEN = 3'd3;
    localparam logic [2:0] PH_INT_VAL = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    logic [2:0]    phase_reg, phase_next;
    logic          second_reg, second_next;
    logic [6:0]    left_reg, left_next;
    logic          strip_reg, strip_next;
    logic [2:0]    err_reg, err_next;
    logic [FB-1:0] r_reg, r_next;
    logic [FB-1:0] s_reg, s_next;

    logic [FB-1:0] cur_field;
    logic [FB+7:0] shift_cat;
    logic [FB-1:0] shifted;

    assign cur_field = second_reg ? s_reg : r_reg;
    assign shift_cat = {cur_field, byte_in};
    assign shifted   = shift_cat[FB-1:0];

    always_comb begin
        phase_next  = phase_reg;
        second_next = second_reg;
        left_next   = left_reg;
        strip_next  = strip_reg;
        err_next    = err_reg;
        r_next      = r_reg;
        s_next      = s_reg;
        done.fire   = 1'b0;
        done.status = der2r_pkg::ST_OK;

        if (take && (err_reg == der2r_pkg::ST_OK)) begin
            unique case (phase_reg)
                PH_SEQ_TAG: begin
                    if (byte_in != der2r_pkg::TAG_SEQUENCE) begin
                        err_next = der2r_pkg::ST_SEQ_TAG;
                    end else begin
                        phase_next = PH_SEQ_LEN;
                    end
                end
                PH_SEQ_LEN: begin
                    phase_next = PH_INT_TAG;
                end
                PH_INT_TAG: begin
                    if (byte_in != der2r_pkg::TAG_INTEGER) begin
                        err_next = der2r_pkg::ST_INT_TAG;
                    end else begin
                        if (second_reg) begin
                            s_next = '0;
                        end else begin
                            r_next = '0;
                        end
                        phase_next = PH_INT_LEN;
                    end
                end
                PH_INT_LEN: begin
                    if (byte_in > der2r_pkg::SHORT_LEN_MAX) begin
                        err_next = der2r_pkg::ST_LONG_LEN;
                    end else begin
                        left_next  = byte_in[6:0];
                        strip_next = 1'b1;
                        if (byte_in[6:0] == 7'd0) begin
                            second_next = 1'b1;
                            phase_next  = second_reg ? PH_DONE : PH_INT_TAG;
                        end else begin
                            phase_next = PH_INT_VAL;
                        end
                    end
                end
                PH_INT_VAL: begin
                    left_next = left_reg - 7'd1;
                    if (!(strip_reg && (byte_in == der2r_pkg::ZERO_BYTE))) begin
                        strip_next = 1'b0;
                        // A value byte with the field already full overflows it.
                        if (cur_field[FB-1 -: 8] != der2r_pkg::ZERO_BYTE) begin
                            err_next = der2r_pkg::ST_TOO_LONG;
                        end else if (second_reg) begin
                            s_next = shifted;
                        end else begin
                            r_next = shifted;
                        end
                    end
                    if ((err_next == der2r_pkg::ST_OK) && (left_next == 7'd0)) begin
                        second_next = 1'b1;
                        phase_next  = second_reg ? PH_DONE : PH_INT_TAG;
                    end
                end
                default: begin
                end
            endcase
        end

        if (take && last_in) begin
            done.fire = 1'b1;
            if ((err_next == der2r_pkg::ST_OK) && (phase_next != PH_DONE)) begin
                done.status = der2r_pkg::ST_TRUNC;
            end else begin
                done.status = err_next;
            end
            phase_next  = PH_SEQ_TAG;
            second_next = 1'b0;
            left_next   = 7'd0;
            strip_next  = 1'b1;
            err_next    = der2r_pkg::ST_OK;
        end
    end

    assign sig_next = {r_next, s_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SEQ_TAG;
            second_reg <= 1'b0;
            left_reg   <= 7'd0;
            strip_reg  <= 1'b1;
            err_reg    <= der2r_pkg::ST_OK;
            r_reg      <= '0;
            s_reg      <= '0;
        end else begin
            phase_reg  <= phase_next;
            second_reg <= second_next;
            left_reg   <= left_next;
            strip_reg  <= strip_next;
            err_reg    <= err_next;
            r_reg      <= r_next;
            s_reg      <= s_next;
        end
    end

endmodule

@@ hw/rtl/der_signature_to_raw_core.sv @@
// Top level of the DER ECDSA signature to raw r||s converter.
`timescale 1ns / 1ps
//
// Channel | Dir | Word contents
// s_      | in  | tdata[7:0] DER byte, tlast marks the final byte of a signature
// m_      | out | tdata[63:0] raw word, tdata[66:64] word index,
//         |     | tuser status, tlast marks the final word of a signature
//
// One DER byte is taken per cycle. The final byte of a signature copies r||s
// into an output buffer that drains one word per cycle while m_tready is high:
// eight words, or one status word on error. Next-signature bytes flow during the
// drain; only its final byte waits until the buffer's last word is taken.
// Reset is synchronous, active low, and leaves the parser expecting a tag.

module der_signature_to_raw_core #(
    parameter int INT_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] der_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] raw_word, [66:64] word_index, rest zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    localparam int SIG_BITS = 2 * INT_BYTES * 8;
    localparam int RAW_BITS = der2r_pkg::RAW_BITS;
    localparam int WB       = der2r_pkg::WORD_BITS;

    der2r_pkg::done_t      done;
    logic [SIG_BITS-1:0]   sig_next;
    logic [RAW_BITS-1:0]   window;
    logic                  s_take;

    logic                  busy_reg, busy_next;
    logic [RAW_BITS-1:0]   buf_reg, buf_next;
    logic [2:0]            idx_reg, idx_next;
    logic [2:0]            stat_reg, stat_next;
    logic                  final_word;
    logic                  m_take;

    der2r_parse #(
        .INT_BYTES (INT_BYTES)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (s_take),
        .byte_in  (s_tdata),
        .last_in  (s_tlast),
        .done     (done),
        .sig_next (sig_next)
    );

    // The output always covers bytes 0..63 of r||s; missing bytes read as zero.
    generate
        if (SIG_BITS >= RAW_BITS) begin : g_wide
            assign window = sig_next[SIG_BITS-1 -: RAW_BITS];
        end else begin : g_narrow
            assign window = {sig_next, {(RAW_BITS - SIG_BITS){1'b0}}};
        end
    endgenerate

    assign final_word = (stat_reg != der2r_pkg::ST_OK) || (idx_reg == 3'd7);
    assign m_take     = busy_reg && m_tready;
    assign s_tready   = !busy_reg || !s_tlast || (m_tready && final_word);
    assign s_take     = s_tvalid && s_tready;

    always_comb begin
        busy_next = busy_reg;
        buf_next  = buf_reg;
        idx_next  = idx_reg;
        stat_next = stat_reg;
        if (done.fire) begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
            stat_next = done.status;
            buf_next  = (done.status == der2r_pkg::ST_OK) ? window : '0;
        end else if (m_take) begin
            if (final_word) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
                buf_next = {buf_reg[RAW_BITS-WB-1:0], {WB{1'b0}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
            stat_reg <= der2r_pkg::ST_OK;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            stat_reg <= stat_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {5'd0, idx_reg, buf_reg[RAW_BITS-1 -: WB]};
    assign m_tuser  = stat_reg;
    assign m_tlast  = final_word;

    // An error word is a single zero word at index zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != der2r_pkg::ST_OK)) |->
            (m_tdata[63:0] == 64'd0) && (m_tdata[66:64] == 3'd0) && m_tlast)
        else $error("error word carries data or a nonzero index");

    // A good signature keeps its burst going until word seven.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tdata[66:64] == $past(m_tdata[66:64]) + 3'd1)))
        else $error("result burst broke off early");

    // The final byte of a signature always starts a fresh result at index zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (m_tvalid && (m_tdata[66:64] == 3'd0)))
        else $error("final byte did not start a result");

    // The final byte is never taken while an unfinished burst is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast && m_tvalid) |-> (m_tready && m_tlast))
        else $error("final byte overran a pending burst");

endmodule

@@ sim/der_signature_to_raw_checker.sv @@
// Checker for the DER signature converter: predicts r||s words from the byte stream and compares.
`timescale 1ns / 1ps

module der_signature_to_raw_checker #(
    parameter int INT_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          expected_left
);

    localparam int SIG_BYTES = 2 * INT_BYTES;

    typedef enum logic [2:0] {
        PH_SEQ_TAG,
        PH_SEQ_LEN,
        PH_INT_TAG,
        PH_INT_LEN,
        PH_INT_VAL,
        PH_DONE
    } parse_phase_t;

    typedef struct packed {
        logic [63:0] raw_word;
        logic [2:0]  word_index;
        logic [2:0]  status;
        logic        last_word;
    } raw_result_t;

    parse_phase_t phase;
    logic         on_s;
    logic [6:0]   bytes_left;
    logic         stripping;
    logic [2:0]   err_code;
    logic [7:0]   sig_bytes [0:SIG_BYTES-1];
    raw_result_t  raw_words_q[$];
    raw_result_t  want;
    int           mismatches;

    assign fail_count = mismatches;

    initial mismatches = 0;

    task automatic restart_parse();
        phase = PH_SEQ_TAG;
        on_s = 1'b0;
        bytes_left = '0;
        stripping = 1'b1;
        err_code = der2r_pkg::ST_OK;
    endtask

    task automatic close_integer();
        if (!on_s) begin
            on_s = 1'b1;
            phase = PH_INT_TAG;
        end else begin
            phase = PH_DONE;
        end
    endtask

    task automatic parse_der_byte(input logic [7:0] b);
        int base;
        base = on_s ? INT_BYTES : 0;
        case (phase)
            PH_SEQ_TAG: begin
                if (b != der2r_pkg::TAG_SEQUENCE) err_code = der2r_pkg::ST_SEQ_TAG;
                else phase = PH_SEQ_LEN;
            end
            PH_SEQ_LEN: begin
                phase = PH_INT_TAG;
            end
            PH_INT_TAG: begin
                if (b != der2r_pkg::TAG_INTEGER) begin
                    err_code = der2r_pkg::ST_INT_TAG;
                end else begin
                    for (int i = 0; i < INT_BYTES; i++) begin
                        sig_bytes[base + i] = der2r_pkg::ZERO_BYTE;
                    end
                    phase = PH_INT_LEN;
                end
            end
            PH_INT_LEN: begin
                if (b > der2r_pkg::SHORT_LEN_MAX) begin
                    err_code = der2r_pkg::ST_LONG_LEN;
                end else begin
                    bytes_left = b[6:0];
                    stripping = 1'b1;
                    if (bytes_left == 0) close_integer();
                    else phase = PH_INT_VAL;
                end
            end
            PH_INT_VAL: begin
                bytes_left = bytes_left - 7'd1;
                if (!(stripping && b == der2r_pkg::ZERO_BYTE)) begin
                    stripping = 1'b0;
                    // A significant byte with the top byte already occupied overflows the field.
                    if (sig_bytes[base] != der2r_pkg::ZERO_BYTE) begin
                        err_code = der2r_pkg::ST_TOO_LONG;
                    end else begin
                        for (int i = 0; i < INT_BYTES - 1; i++) begin
                            sig_bytes[base + i] = sig_bytes[base + i + 1];
                        end
                        sig_bytes[base + INT_BYTES - 1] = b;
                    end
                end
                if (err_code == der2r_pkg::ST_OK && bytes_left == 0) close_integer();
            end
            default: ;
        endcase
    endtask

    task automatic emit_raw_words();
        raw_result_t r;
        int          idx;
        if (err_code == der2r_pkg::ST_OK && phase != PH_DONE) err_code = der2r_pkg::ST_TRUNC;
        if (err_code != der2r_pkg::ST_OK) begin
            r.raw_word = '0;
            r.word_index = '0;
            r.status = err_code;
            r.last_word = 1'b1;
            raw_words_q.push_back(r);
        end else begin
            for (int k = 0; k < der2r_pkg::OUT_WORDS; k++) begin
                r.raw_word = '0;
                for (int j = 0; j < 8; j++) begin
                    idx = k * 8 + j;
                    r.raw_word = {r.raw_word[55:0],
                                  (idx < SIG_BYTES) ? sig_bytes[idx] : der2r_pkg::ZERO_BYTE};
                end
                r.word_index = k[2:0];
                r.status = der2r_pkg::ST_OK;
                r.last_word = (k == der2r_pkg::OUT_WORDS - 1);
                raw_words_q.push_back(r);
            end
        end
        restart_parse();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_parse();
            for (int i = 0; i < SIG_BYTES; i++) sig_bytes[i] = der2r_pkg::ZERO_BYTE;
            raw_words_q.delete();
            expected_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (raw_words_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected word tdata=%h tuser=%0d tlast=%0b",
                                 $realtime, m_tdata, m_tuser, m_tlast);
                    end
                    mismatches++;
                end else begin
                    want = raw_words_q.pop_front();
                    if (m_tdata !== {5'b0, want.word_index, want.raw_word} ||
                        m_tuser !== want.status || m_tlast !== want.last_word) begin
                        if (mismatches < 10) begin
                            $display("%0t: word mismatch", $realtime);
                            $display("  expected raw=%h index=%0d status=%0d last=%0b",
                                     want.raw_word, want.word_index, want.status,
                                     want.last_word);
                            $display("  actual   raw=%h index=%0d status=%0d last=%0b pad=%h",
                                     m_tdata[63:0], m_tdata[66:64], m_tuser, m_tlast,
                                     m_tdata[71:67]);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                // Once an error is latched, bytes are dropped until the final one.
                if (err_code == der2r_pkg::ST_OK) parse_der_byte(s_tdata);
                if (s_tlast) emit_raw_words();
            end
            expected_left <= raw_words_q.size();
        end
    end

endmodule

@@ sim/der_signature_to_raw_core_tb.sv @@
// Testbench top for the DER signature converter: drives byte streams and gives the verdict.
`timescale 1ns / 1ps

module der_signature_to_raw_core_tb;

    localparam int SIG_INT_BYTES = 32;
    localparam int RANDOM_BYTES  = 450;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          expected_left;

    bit          tx_idle;
    bit          rx_idle;
    int          rx_hold;
    int          bytes_sent;
    logic [7:0]  der_q[$];

    der_signature_to_raw_core #(
        .INT_BYTES(SIG_INT_BYTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    der_signature_to_raw_checker #(
        .INT_BYTES(SIG_INT_BYTES)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .expected_left(expected_left)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    // Sends the queued bytes as one signature, flagging the final byte.
    task automatic send_signature();
        int gap;
        for (int i = 0; i < der_q.size(); i++) begin
            gap = tx_idle ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= der_q[i];
            s_tlast <= (i == der_q.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            bytes_sent++;
        end
        der_q.delete();
    endtask

    // Stops offering bytes and waits until every predicted word has come out.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
    endtask

    task automatic add_integer();
        int pick;
        int n;
        int zeros;
        pick = $urandom_range(0, 99);
        if (pick < 10) n = 0;
        else if (pick < 60) n = $urandom_range(1, 8);
        else if (pick < 85) n = $urandom_range(30, 33);
        else if (pick < 95) n = $urandom_range(34, 40);
        else n = $urandom_range(41, 127);
        zeros = 0;
        if (n > 0 && $urandom_range(0, 3) == 0) zeros = $urandom_range(1, (n < 4) ? n : 4);
        der_q.push_back(der2r_pkg::TAG_INTEGER);
        der_q.push_back(n[7:0]);
        for (int i = 0; i < n; i++) begin
            der_q.push_back((i < zeros) ? der2r_pkg::ZERO_BYTE : 8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly well-formed signatures with random content; the rest is damaged or noise.
    task automatic build_signature(input bit clean);
        int kind;
        int cut;
        kind = clean ? 0 : $urandom_range(0, 99);
        der_q.delete();
        der_q.push_back(der2r_pkg::TAG_SEQUENCE);
        der_q.push_back(8'($urandom_range(0, 255)));
        add_integer();
        add_integer();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) der_q.push_back(8'($urandom_range(0, 255)));
        end
        if (kind >= 75 && kind < 85) begin
            der_q[$urandom_range(0, der_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (kind >= 85 && kind < 93) begin
            cut = $urandom_range(1, der_q.size() - 1);
            while (der_q.size() > cut) void'(der_q.pop_back());
        end else if (kind >= 93) begin
            der_q.delete();
            repeat ($urandom_range(1, 6)) der_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Result side: random back-pressure, plus a long hold-off on request.
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 5) : 0;
            if (rx_hold > 0) begin
                gap = rx_hold;
                rx_hold = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        rx_hold = 0;
        bytes_sent = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Bad sequence tag on a lone final byte.
        der_q = '{8'h00};
        send_signature();
        // Truncated right after the sequence length.
        der_q = '{der2r_pkg::TAG_SEQUENCE, 8'h45};
        send_signature();
        // Wrong integer tag.
        der_q = '{der2r_pkg::TAG_SEQUENCE, 8'h00, 8'h05};
        send_signature();
        // Long-form length at the first value above the short-form range.
        der_q = '{der2r_pkg::TAG_SEQUENCE, 8'hff, der2r_pkg::TAG_INTEGER, 8'h80};
        send_signature();
        // Two zero-length integers, then a trailing byte that must be ignored.
        der_q = '{der2r_pkg::TAG_SEQUENCE, 8'h06, der2r_pkg::TAG_INTEGER, 8'h00,
                  der2r_pkg::TAG_INTEGER, 8'h00, 8'hff};
        send_signature();
        // Leading zero stripped from r; s carries an all-ones byte.
        der_q = '{der2r_pkg::TAG_SEQUENCE, 8'h08, der2r_pkg::TAG_INTEGER, 8'h02, 8'h00, 8'h80,
                  der2r_pkg::TAG_INTEGER, 8'h02, 8'hff, 8'h01};
        send_signature();
        wait_for_drain();

        // Hold the result side while more signatures arrive, so the input backs up.
        rx_hold = 600;
        repeat (3) begin
            build_signature(1'b1);
            send_signature();
        end
        wait_for_drain();

        while (bytes_sent < RANDOM_BYTES) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            build_signature(1'b0);
            send_signature();
            if (bytes_sent >= RANDOM_BYTES / 2 && bytes_sent < RANDOM_BYTES / 2 + 40) begin
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/der2r_pkg.sv
hw/rtl/der2r_parse.sv
hw/rtl/der_signature_to_raw_core.sv
sim/der_signature_to_raw_checker.sv
sim/der_signature_to_raw_core_tb.sv
